// ===== rtl/lsoa_pkg.sv =====
// Package for the lidar sector obstacle avoider: request and result types,
// configuration register set and fixed drive constants. No dependencies.
package lsoa_pkg;

  localparam int RangeW  = 16;
  localparam int IdxW    = 10;
  localparam int SpeedW  = 15;
  localparam int OffsetW = 17;
  localparam int RateW   = 12;
  localparam int CfgDataW = 16;

  localparam logic [RangeW-1:0] RANGE_MAX   = '1;
  localparam logic [RangeW-1:0] TURN_LINEAR = 16'd800;
  localparam logic signed [RateW-1:0] TURN_ANGULAR = 12'sd2000;
  localparam logic signed [15:0] STOP_STEP = -16'sd1000;
  localparam logic signed [OffsetW:0] OFFSET_MAX = 18'sd32767;

  typedef enum logic [1:0] {
    ACT_FORWARD = 2'd0,
    ACT_LEFT    = 2'd1,
    ACT_RIGHT   = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    REG_RIGHT_FIRST     = 3'd0,
    REG_RIGHT_LAST      = 3'd1,
    REG_FRONT_FIRST     = 3'd2,
    REG_FRONT_LAST      = 3'd3,
    REG_LEFT_FIRST      = 3'd4,
    REG_LEFT_LAST       = 3'd5,
    REG_FRONT_THRESHOLD = 3'd6,
    REG_START_SPEED     = 3'd7
  } cfg_idx_t;

  localparam logic OP_RANGE  = 1'b0;
  localparam logic OP_OFFSET = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [RangeW-1:0]  range_mm;
    logic               scan_end;
    logic signed [15:0] speed_step;
  } in_item_t;

  typedef struct packed {
    action_t                  action;
    logic [RangeW-1:0]        linear_speed;
    logic signed [RateW-1:0]  angular_rate;
  } out_item_t;

  typedef struct packed {
    logic [IdxW-1:0]   right_first;
    logic [IdxW-1:0]   right_last;
    logic [IdxW-1:0]   front_first;
    logic [IdxW-1:0]   front_last;
    logic [IdxW-1:0]   left_first;
    logic [IdxW-1:0]   left_last;
    logic [RangeW-1:0] front_threshold;
    logic [SpeedW-1:0] start_speed;
  } cfg_regs_t;

  typedef struct packed {
    logic [RangeW-1:0] right;
    logic [RangeW-1:0] front;
    logic [RangeW-1:0] left;
  } sector_mins_t;

endpackage

// ===== rtl/lidar_sector_obstacle_avoider.sv =====
// Top level of the lidar sector obstacle avoider: input register, sector
// minima, speed offset and result register. Depends on lsoa_pkg, lsoa_cmd.
//
// One request enters per cycle unless the input side stalls: a request is held
// in the input register while its range is folded into the right, front and
// left minima, and a scan-end sample loads the drive command into the result
// register from the input register. The input side stalls only when a scan-end request
// meets an occupied result register that is not being taken. Sample positions
// count 0..MAX_SAMPLES-1 and wrap; configuration writes take effect at once.
module lidar_sector_obstacle_avoider #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  lsoa_pkg::in_item_t               in_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output lsoa_pkg::out_item_t              out_item,
  input  logic                             cfg_we,
  input  lsoa_pkg::cfg_idx_t               cfg_idx,
  input  logic [lsoa_pkg::CfgDataW-1:0]    cfg_data
);
  import lsoa_pkg::*;

  localparam int PosW = $clog2(MAX_SAMPLES);
  localparam int CmpW = (PosW > IdxW) ? PosW : IdxW;
  localparam logic [PosW-1:0] PosLast = PosW'(MAX_SAMPLES - 1);

  cfg_regs_t              cfg_r;
  logic                   s1_valid_r;
  in_item_t               s1_item_r;
  logic [PosW-1:0]        pos_r;
  sector_mins_t           mins_r;
  sector_mins_t           mins_nxt;
  logic signed [OffsetW-1:0] offset_r;
  logic signed [OffsetW:0]   offset_sum;
  logic signed [OffsetW:0]   offset_low;
  logic signed [OffsetW:0]   offset_nxt;
  logic                   out_valid_r;
  out_item_t              out_item_r;
  out_item_t              cmd;
  logic                   s1_emits;
  logic                   s1_go;
  logic [CmpW-1:0]        pos_cmp;

  function automatic logic in_win(logic [CmpW-1:0] pos, logic [IdxW-1:0] first,
                                  logic [IdxW-1:0] last);
    in_win = (pos >= CmpW'(first)) && (pos <= CmpW'(last));
  endfunction

  assign s1_emits  = s1_valid_r && (s1_item_r.opcode == OP_RANGE) && s1_item_r.scan_end;
  assign s1_go     = s1_valid_r && (!s1_emits || !out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_go;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign pos_cmp   = CmpW'(pos_r);

  always_comb begin
    mins_nxt = mins_r;
    if (in_win(pos_cmp, cfg_r.right_first, cfg_r.right_last) &&
        s1_item_r.range_mm < mins_r.right) begin
      mins_nxt.right = s1_item_r.range_mm;
    end
    if (in_win(pos_cmp, cfg_r.front_first, cfg_r.front_last) &&
        s1_item_r.range_mm < mins_r.front) begin
      mins_nxt.front = s1_item_r.range_mm;
    end
    if (in_win(pos_cmp, cfg_r.left_first, cfg_r.left_last) &&
        s1_item_r.range_mm < mins_r.left) begin
      mins_nxt.left = s1_item_r.range_mm;
    end
  end

  always_comb begin
    offset_sum = {offset_r[OffsetW-1], offset_r} +
                 {{(OffsetW + 1 - 16){s1_item_r.speed_step[15]}}, s1_item_r.speed_step};
    offset_low = -$signed({3'b000, cfg_r.start_speed});
    offset_nxt = offset_sum;
    if (offset_sum > OFFSET_MAX) begin
      offset_nxt = OFFSET_MAX;
    end
    if (offset_sum < offset_low || s1_item_r.speed_step == STOP_STEP) begin
      offset_nxt = offset_low;
    end
  end

  lsoa_cmd u_cmd (
    .mins         (mins_nxt),
    .cfg          (cfg_r),
    .speed_offset (offset_r),
    .cmd          (cmd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.right_first     <= 10'd20;
      cfg_r.right_last      <= 10'd120;
      cfg_r.front_first     <= 10'd300;
      cfg_r.front_last      <= 10'd420;
      cfg_r.left_first      <= 10'd600;
      cfg_r.left_last       <= 10'd700;
      cfg_r.front_threshold <= 16'd1500;
      cfg_r.start_speed     <= 15'd2000;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_RIGHT_FIRST:     cfg_r.right_first     <= cfg_data[IdxW-1:0];
        REG_RIGHT_LAST:      cfg_r.right_last      <= cfg_data[IdxW-1:0];
        REG_FRONT_FIRST:     cfg_r.front_first     <= cfg_data[IdxW-1:0];
        REG_FRONT_LAST:      cfg_r.front_last      <= cfg_data[IdxW-1:0];
        REG_LEFT_FIRST:      cfg_r.left_first      <= cfg_data[IdxW-1:0];
        REG_LEFT_LAST:       cfg_r.left_last       <= cfg_data[IdxW-1:0];
        REG_FRONT_THRESHOLD: cfg_r.front_threshold <= cfg_data[RangeW-1:0];
        REG_START_SPEED:     cfg_r.start_speed     <= cfg_data[SpeedW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      mins_r   <= {3{RANGE_MAX}};
      offset_r <= '0;
    end else if (s1_go) begin
      if (s1_item_r.opcode == OP_OFFSET) begin
        offset_r <= offset_nxt[OffsetW-1:0];
      end else if (s1_item_r.scan_end) begin
        pos_r  <= '0;
        mins_r <= {3{RANGE_MAX}};
      end else begin
        pos_r  <= (pos_r == PosLast) ? '0 : pos_r + 1'b1;
        mins_r <= mins_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_emits) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emits) begin
      out_item_r <= cmd;
    end
  end

  a_fwd_no_yaw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.action == ACT_FORWARD |-> out_item.angular_rate == '0)
    else $error("forward command with nonzero yaw rate");

  a_turn_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.action == ACT_LEFT || out_item.action == ACT_RIGHT)
    |-> out_item.linear_speed == TURN_LINEAR)
    else $error("turn command with wrong linear speed");

  a_scan_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_emits |=> pos_r == '0 && mins_r == {3{RANGE_MAX}})
    else $error("scan state not cleared after scan end");

  a_offset_cap: assert property (@(posedge clk) disable iff (!rst_n)
    $signed({offset_r[OffsetW-1], offset_r}) <= OFFSET_MAX)
    else $error("speed offset above saturation limit");

  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready && s1_emits |-> !s1_go)
    else $error("result register overwritten while pending");

endmodule

// ===== rtl/lsoa_cmd.sv =====
// Drive command decision from the three sector minima and the speed offset.
// Depends on lsoa_pkg.
module lsoa_cmd (
  input  lsoa_pkg::sector_mins_t               mins,
  input  lsoa_pkg::cfg_regs_t                  cfg,
  input  logic signed [lsoa_pkg::OffsetW-1:0]  speed_offset,
  output lsoa_pkg::out_item_t                  cmd
);
  import lsoa_pkg::*;

  logic signed [OffsetW:0] fwd_sum;

  assign fwd_sum = $signed({3'b000, cfg.start_speed}) + {speed_offset[OffsetW-1], speed_offset};

  always_comb begin
    cmd = '0;
    if (mins.front < cfg.front_threshold) begin
      cmd.linear_speed = TURN_LINEAR;
      if (mins.right < mins.left) begin
        cmd.action       = ACT_LEFT;
        cmd.angular_rate = TURN_ANGULAR;
      end else begin
        cmd.action       = ACT_RIGHT;
        cmd.angular_rate = -TURN_ANGULAR;
      end
    end else begin
      cmd.action       = ACT_FORWARD;
      cmd.angular_rate = '0;
      priority if (fwd_sum < 0) begin
        cmd.linear_speed = '0;
      end else if (fwd_sum > $signed({2'b00, RANGE_MAX})) begin
        cmd.linear_speed = RANGE_MAX;
      end else begin
        cmd.linear_speed = fwd_sum[RangeW-1:0];
      end
    end
  end

endmodule

// ===== tb/lsoa_drive_checker.sv =====
// Checker for the lidar sector obstacle avoider: mirrors the configuration
// writes, predicts the drive command of each scan and compares accepted results.
// Depends on lsoa_pkg.
module lsoa_drive_checker #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  lsoa_pkg::in_item_t             in_item,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  lsoa_pkg::out_item_t            out_item,
  input  logic                           cfg_we,
  input  lsoa_pkg::cfg_idx_t             cfg_idx,
  input  logic [lsoa_pkg::CfgDataW-1:0]  cfg_data,
  output int                             pending,
  output int                             mismatches
);
  import lsoa_pkg::*;

  cfg_regs_t         regs;
  int                scan_pos;
  logic [RangeW-1:0] min_right;
  logic [RangeW-1:0] min_front;
  logic [RangeW-1:0] min_left;
  int                offset;
  out_item_t         commands_due [$];
  int                errs = 0;

  assign mismatches = errs;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] drive command %s mismatch: got %0d, expected %0d", $realtime, what,
             got, want);
    errs++;
  endtask

  task automatic clear_scan();
    scan_pos  = 0;
    min_right = RANGE_MAX;
    min_front = RANGE_MAX;
    min_left  = RANGE_MAX;
  endtask

  task automatic restore_defaults();
    regs.right_first     = 10'd20;
    regs.right_last      = 10'd120;
    regs.front_first     = 10'd300;
    regs.front_last      = 10'd420;
    regs.left_first      = 10'd600;
    regs.left_last       = 10'd700;
    regs.front_threshold = 16'd1500;
    regs.start_speed     = 15'd2000;
    offset = 0;
    clear_scan();
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] data);
    case (idx)
      REG_RIGHT_FIRST:     regs.right_first = data[IdxW-1:0];
      REG_RIGHT_LAST:      regs.right_last = data[IdxW-1:0];
      REG_FRONT_FIRST:     regs.front_first = data[IdxW-1:0];
      REG_FRONT_LAST:      regs.front_last = data[IdxW-1:0];
      REG_LEFT_FIRST:      regs.left_first = data[IdxW-1:0];
      REG_LEFT_LAST:       regs.left_last = data[IdxW-1:0];
      REG_FRONT_THRESHOLD: regs.front_threshold = data[RangeW-1:0];
      REG_START_SPEED:     regs.start_speed = data[SpeedW-1:0];
      default: ;
    endcase
  endtask

  function automatic bit in_span(input int p, input logic [IdxW-1:0] lo,
                                 input logic [IdxW-1:0] hi);
    return p >= int'(lo) && p <= int'(hi);
  endfunction

  task automatic take_request(input in_item_t rq);
    int        lower;
    int        sum;
    int        speed;
    out_item_t cmd;
    if (rq.opcode == OP_OFFSET) begin
      lower = -int'(regs.start_speed);
      sum = offset + int'(rq.speed_step);
      if (sum > int'(OFFSET_MAX)) sum = int'(OFFSET_MAX);
      if (sum < lower || rq.speed_step == STOP_STEP) sum = lower;
      offset = sum;
    end else begin
      if (in_span(scan_pos, regs.right_first, regs.right_last) && rq.range_mm < min_right)
        min_right = rq.range_mm;
      if (in_span(scan_pos, regs.front_first, regs.front_last) && rq.range_mm < min_front)
        min_front = rq.range_mm;
      if (in_span(scan_pos, regs.left_first, regs.left_last) && rq.range_mm < min_left)
        min_left = rq.range_mm;
      if (!rq.scan_end) begin
        scan_pos = (scan_pos >= MAX_SAMPLES - 1) ? 0 : scan_pos + 1;
      end else begin
        if (min_front < regs.front_threshold) begin
          cmd.linear_speed = TURN_LINEAR;
          if (min_right < min_left) begin
            cmd.action       = ACT_LEFT;
            cmd.angular_rate = TURN_ANGULAR;
          end else begin
            cmd.action       = ACT_RIGHT;
            cmd.angular_rate = -TURN_ANGULAR;
          end
        end else begin
          speed = int'(regs.start_speed) + offset;
          if (speed < 0) speed = 0;
          if (speed > 65535) speed = 65535;
          cmd.action       = ACT_FORWARD;
          cmd.linear_speed = speed[RangeW-1:0];
          cmd.angular_rate = '0;
        end
        commands_due.push_back(cmd);
        clear_scan();
      end
    end
  endtask

  task automatic check_command(input out_item_t got);
    out_item_t want;
    if (commands_due.size() == 0) begin
      $display("[%0t] drive command with none outstanding: action %0d speed %0d rate %0d",
               $realtime, got.action, got.linear_speed, got.angular_rate);
      errs++;
    end else begin
      want = commands_due.pop_front();
      if (got.action !== want.action)
        report_mismatch("action", int'(got.action), int'(want.action));
      if (got.linear_speed !== want.linear_speed)
        report_mismatch("linear_speed", int'(got.linear_speed), int'(want.linear_speed));
      if (got.angular_rate !== want.angular_rate)
        report_mismatch("angular_rate", int'(got.angular_rate), int'(want.angular_rate));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      restore_defaults();
      commands_due.delete();
    end else begin
      if (cfg_we) write_reg(cfg_idx, cfg_data);
      if (out_valid && out_ready) check_command(out_item);
      if (in_valid && in_ready) take_request(in_item);
    end
    pending <= commands_due.size();
  end

endmodule

// ===== tb/lidar_sector_obstacle_avoider_test.sv =====
// Testbench top for the lidar sector obstacle avoider: clock, reset, directed
// and random scans, offset steps and register writes, and the verdict.
// Depends on lsoa_pkg, lidar_sector_obstacle_avoider and lsoa_drive_checker.
module lidar_sector_obstacle_avoider_test;
  import lsoa_pkg::*;

  localparam int ItemsTotal  = 1850;
  localparam int ScansWanted = 60;
  localparam int LimitCycles = 2_000_000;
  localparam int ItemW       = $bits(in_item_t);

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_item;
  logic                cfg_we = 1'b0;
  cfg_idx_t            cfg_idx = REG_RIGHT_FIRST;
  logic [CfgDataW-1:0] cfg_data = '0;

  int  pending;
  int  mismatches;
  int  sent = 0;
  int  scans = 0;
  bit  steady = 1'b0;
  int  thr = 1500;

  always #5 clk = ~clk;

  lidar_sector_obstacle_avoider dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data)
  );

  lsoa_drive_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .mismatches (mismatches)
  );

  function automatic int idle_cycles();
    int r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [RangeW-1:0] pick_range();
    int r = $urandom_range(0, 99);
    int v;
    if (r < 10) return '0;
    if (r < 20) return RANGE_MAX;
    if (r < 40) begin
      v = thr + int'($urandom_range(0, 2)) - 1;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[RangeW-1:0];
    end
    if (r < 75) return RangeW'($urandom_range(0, 8000));
    return RangeW'($urandom_range(0, 65535));
  endfunction

  function automatic logic signed [15:0] pick_step();
    case ($urandom_range(0, 9))
      0, 1: return STOP_STEP;
      2: return 16'sd32767;
      3: return -16'sd32768;
      4: return ($urandom_range(0, 1) != 0) ? -16'sd999 : -16'sd1001;
      5, 6: return 16'(int'($urandom_range(0, 6000)) - 3000);
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic in_item_t range_req(input logic [RangeW-1:0] range_mm, input logic last);
    in_item_t rq;
    rq.opcode     = OP_RANGE;
    rq.range_mm   = range_mm;
    rq.scan_end   = last;
    rq.speed_step = 16'($urandom_range(0, 65535));
    return rq;
  endfunction

  function automatic in_item_t step_req(input logic signed [15:0] step);
    in_item_t rq;
    rq.opcode     = OP_OFFSET;
    rq.range_mm   = RangeW'($urandom_range(0, 65535));
    rq.scan_end   = 1'($urandom_range(0, 1));
    rq.speed_step = step;
    return rq;
  endfunction

  task automatic issue_request(input in_item_t rq);
    int gap;
    in_item  <= rq;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent++;
    gap = steady ? 0 : idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [CfgDataW-1:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= cfg_idx_t'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic pick_window(input int span, input bit wild,
                             output logic [CfgDataW-1:0] first,
                             output logic [CfgDataW-1:0] last);
    int a = $urandom_range(0, span - 1);
    int b = $urandom_range(0, span - 1);
    if (wild) begin
      first = CfgDataW'($urandom_range(0, 65535));
      last  = CfgDataW'($urandom_range(0, 65535));
    end else if ($urandom_range(0, 19) == 0) begin
      first = '0;
      last  = 16'd1023;
    end else if ($urandom_range(0, 6) == 0) begin
      first = CfgDataW'((a > b) ? a : b);
      last  = CfgDataW'((a > b) ? b : a);
    end else begin
      first = CfgDataW'((a < b) ? a : b);
      last  = CfgDataW'((a < b) ? b : a);
    end
  endtask

  task automatic pick_config(input int span, input bit wild,
                             output logic [CfgDataW-1:0] vals [8]);
    pick_window(span, wild, vals[REG_RIGHT_FIRST], vals[REG_RIGHT_LAST]);
    pick_window(span, wild, vals[REG_FRONT_FIRST], vals[REG_FRONT_LAST]);
    pick_window(span, wild, vals[REG_LEFT_FIRST], vals[REG_LEFT_LAST]);
    case ($urandom_range(0, 5))
      0: vals[REG_FRONT_THRESHOLD] = 16'd0;
      1: vals[REG_FRONT_THRESHOLD] = 16'hFFFF;
      2: vals[REG_FRONT_THRESHOLD] = CfgDataW'($urandom_range(0, 65535));
      default: vals[REG_FRONT_THRESHOLD] = CfgDataW'($urandom_range(200, 5000));
    endcase
    case ($urandom_range(0, 5))
      0: vals[REG_START_SPEED] = 16'd0;
      1: vals[REG_START_SPEED] = 16'd32767;
      2: vals[REG_START_SPEED] = CfgDataW'($urandom_range(0, 65535));
      default: vals[REG_START_SPEED] = CfgDataW'($urandom_range(0, 5000));
    endcase
    thr = int'(vals[REG_FRONT_THRESHOLD]);
  endtask

  task automatic run_scan(input int len);
    logic [ItemW-1:0] raw;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 24) == 0) begin
        raw = ItemW'({$urandom, $urandom});
        issue_request(in_item_t'(raw));
      end
      if ($urandom_range(0, 11) == 0) issue_request(step_req(pick_step()));
      issue_request(range_req(pick_range(), i == len - 1));
    end
    scans++;
  endtask

  initial begin
    logic [CfgDataW-1:0] vals [8];
    int phase;
    int span;
    int phase_end;
    bit wild;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue_request(range_req(16'd0, 1'b1));
    issue_request(step_req(16'sd32767));
    issue_request(range_req(16'hFFFF, 1'b1));
    issue_request(step_req(-16'sd32768));
    issue_request(step_req(STOP_STEP));
    issue_request(range_req(16'd1500, 1'b1));

    hold_until_drained();
    vals = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'hFFFF, 16'd32767};
    program_regs(vals);
    thr = 65535;
    issue_request(range_req(16'd400, 1'b0));
    issue_request(range_req(16'd500, 1'b0));
    issue_request(range_req(16'd100, 1'b0));
    issue_request(range_req(16'hFFFF, 1'b0));
    issue_request(range_req(16'd500, 1'b0));
    issue_request(range_req(16'd500, 1'b1));
    issue_request(range_req(16'd500, 1'b0));
    issue_request(range_req(16'd500, 1'b0));
    issue_request(range_req(16'd0, 1'b0));
    issue_request(range_req(16'd7, 1'b0));
    issue_request(range_req(16'd300, 1'b0));
    issue_request(range_req(16'hFFFF, 1'b1));
    issue_request(range_req(16'd5, 1'b0));
    issue_request(range_req(16'd6, 1'b0));
    issue_request(range_req(16'd1, 1'b0));
    issue_request(range_req(16'd2, 1'b0));
    issue_request(range_req(16'd6, 1'b0));
    issue_request(range_req(16'd5, 1'b1));

    phase = 0;
    while (sent < ItemsTotal || scans < ScansWanted) begin
      hold_until_drained();
      wild = 1'b0;
      case (phase % 6)
        0: span = 8;
        1: span = 24;
        2: span = 64;
        3: span = 160;
        4: begin
          span = 1024;
          wild = 1'b1;
        end
        default: begin
          span = 32;
          steady = 1'b1;
        end
      endcase
      if (phase == 3) begin
        vals = '{16'd1000, 16'd1023, 16'd0, 16'd7, 16'd1016, 16'd1023, 16'd0, 16'd0};
        vals[REG_FRONT_THRESHOLD] = CfgDataW'($urandom_range(200, 5000));
        vals[REG_START_SPEED] = CfgDataW'($urandom_range(0, 32767));
        thr = int'(vals[REG_FRONT_THRESHOLD]);
        program_regs(vals);
        run_scan($urandom_range(1030, 1060));
      end else begin
        pick_config(span, wild, vals);
        program_regs(vals);
        phase_end = sent + $urandom_range(100, 200);
        while (sent < phase_end) begin
          run_scan(wild ? $urandom_range(1, 80) : 1 + $urandom_range(0, span + span / 4));
          if ($urandom_range(0, 15) == 0) hold_until_drained();
        end
      end
      steady = 1'b0;
      phase++;
    end

    hold_until_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("[lidar_sector_obstacle_avoider] OK");
    end else begin
      $display("[lidar_sector_obstacle_avoider] ERROR");
    end
    $finish;
  end

  initial begin
    @(posedge clk);
    forever begin
      if (steady) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat (1 + idle_cycles()) @(posedge clk);
        out_ready <= 1'b0;
        repeat (1 + idle_cycles()) @(posedge clk);
      end
    end
  end

  initial begin
    #(LimitCycles * 10);
    $display("[lidar_sector_obstacle_avoider] ERROR");
    $finish;
  end

endmodule
